// ===== src/stc_pkg.sv =====
package stc_pkg;

	// Default widths of the length and line counters.
	localparam int LENGTH_BITS_DEF = 16;
	localparam int LINE_BITS_DEF   = 24;

	// Lexer state codes.
	localparam int STATE_BITS = 5;
	typedef logic [STATE_BITS-1:0] lex_state_t;

	localparam lex_state_t ST_IDLE = 5'd0;
	localparam lex_state_t ST_O0   = 5'd1;
	localparam lex_state_t ST_O1   = 5'd2;
	localparam lex_state_t ST_O2   = 5'd3;
	localparam lex_state_t ST_O3   = 5'd4;
	localparam lex_state_t ST_O4   = 5'd5;
	localparam lex_state_t ST_O5   = 5'd6;
	localparam lex_state_t ST_O6   = 5'd7;
	localparam lex_state_t ST_I0   = 5'd8;
	localparam lex_state_t ST_I1   = 5'd9;
	localparam lex_state_t ST_F0   = 5'd10;
	localparam lex_state_t ST_F1   = 5'd11;
	localparam lex_state_t ST_F2   = 5'd12;
	localparam lex_state_t ST_V0   = 5'd13;
	localparam lex_state_t ST_S0   = 5'd14;
	localparam lex_state_t ST_S1   = 5'd15;
	localparam lex_state_t ST_S2   = 5'd16;
	localparam lex_state_t ST_C0   = 5'd17;
	localparam lex_state_t ST_C1   = 5'd18;
	localparam lex_state_t ST_E0   = 5'd19;
	localparam lex_state_t ST_E1   = 5'd20;
	localparam lex_state_t ST_E2   = 5'd21;
	localparam lex_state_t ST_E3   = 5'd22;
	localparam lex_state_t ST_E4   = 5'd23;
	localparam lex_state_t ST_E5   = 5'd24;
	localparam lex_state_t ST_E6   = 5'd25;
	localparam lex_state_t ST_E7   = 5'd26;
	localparam lex_state_t ST_E8   = 5'd27;
	localparam lex_state_t ST_E9   = 5'd28;

	// Token kinds.
	typedef logic [2:0] kind_t;
	localparam kind_t K_OP     = 3'd0;
	localparam kind_t K_INT    = 3'd1;
	localparam kind_t K_FLT    = 3'd2;
	localparam kind_t K_ID     = 3'd3;
	localparam kind_t K_STR    = 3'd4;
	localparam kind_t K_COM    = 3'd5;
	localparam kind_t K_BADNUM = 3'd6;
	localparam kind_t K_BAD    = 3'd7;

	// Character codes.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// Decoded properties of one byte; all flags are low for the end marker
	// and for bytes at 0x80 and above.
	typedef struct packed {
		logic dig;
		logic alpha;
		logic prnt;
		logic blk;
		logic sp_tab;
		logic nl;
		logic slash;
		logic star;
		logic pct;
		logic plus_minus;
		logic eq;
		logic dot;
		logic zero;
		logic squote;
		logic dquote;
		logic bslash;
		logic hash;
		logic exp_e;
	} char_class_t;

endpackage

// ===== src/source_text_token_classifier.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready   text_byte, end_of_text
// out      output     out_valid / out_ready token_kind, unknown_run, token_length,
//                                           line_number
//
// One item is taken per cycle while the output does not stall; the lexer steps it
// between the input and output registers, so a result, if any, is loaded into the
// output register when the item is processed. The update for a byte is one short
// step of logic, so a fresh item can follow in every cycle unless the output stalls.
// Reset clears the lexer to idle with the line count at one; no clearing pass.
// A stalled output holds the item in the input register; in_ready then drops.
module source_text_token_classifier #(
	parameter int LENGTH_BITS = stc_pkg::LENGTH_BITS_DEF,
	parameter int LINE_BITS   = stc_pkg::LINE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_text,
	output logic                   out_valid,
	input  logic                   out_ready,
	output stc_pkg::kind_t         token_kind,
	output logic                   unknown_run,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic [LINE_BITS-1:0]   line_number
);
	import stc_pkg::*;

	// Input register: the accepted byte waits here until the output side has room.
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// The item in the input register is processed when the output register is
	// empty or is being emptied in the same cycle.
	logic proc;

	char_class_t            cls;
	logic                   res_valid;
	kind_t                  res_kind;
	logic                   res_run;
	logic [LENGTH_BITS-1:0] res_len;
	logic [LINE_BITS-1:0]   res_line;

	// Output register.
	logic                   out_valid_q;
	kind_t                  kind_q;
	logic                   run_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LINE_BITS-1:0]   line_q;

	assign proc     = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	// The payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// Byte decode feeding the automaton.
	stc_classify u_classify (
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.cls         (cls)
	);

	// Lexer state and its one-step update; it advances only on a processed item.
	stc_lexer #(
		.LENGTH_BITS (LENGTH_BITS),
		.LINE_BITS   (LINE_BITS)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (proc),
		.end_of_text (eot_s1),
		.cls         (cls),
		.res_valid   (res_valid),
		.res_kind    (res_kind),
		.res_run     (res_run),
		.res_len     (res_len),
		.res_line    (res_line)
	);

	// The output register fills on a processed item with a result, and empties
	// when the result is taken without a new one arriving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			kind_q <= res_kind;
			run_q  <= res_run;
			len_q  <= res_len;
			line_q <= res_line;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = kind_q;
	assign unknown_run  = run_q;
	assign token_length = len_q;
	assign line_number  = line_q;

	// A run of unknown bytes is always reported with the bad kind.
	a_run_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && run_q |-> kind_q == K_BAD)
		else $error("unknown run reported with a wrong kind");

	// A reported line is never zero.
	a_line_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> line_q != '0)
		else $error("result reported on line zero");

	// A result produced by a processed item is presented in the next cycle.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		proc && res_valid |=> out_valid_q)
		else $error("result lost between lexer and output register");

endmodule

// ===== src/stc_classify.sv =====
module stc_classify (
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output stc_pkg::char_class_t cls
);
	import stc_pkg::*;

	logic live;

	// A byte with the top bit set, or the end marker, matches no class.
	assign live = !end_of_text && !text_byte[7];

	always_comb begin
		cls.dig        = live && text_byte >= CH_ZERO && text_byte <= CH_NINE;
		cls.alpha      = live && ((text_byte >= CH_LO_A && text_byte <= CH_LO_Z)
		                 || (text_byte >= CH_UP_A && text_byte <= CH_UP_Z)
		                 || text_byte == CH_UNDER);
		cls.prnt       = live && text_byte >= CH_SPACE && text_byte <= CH_TILDE;
		cls.blk        = live && ((text_byte >= CH_HASH && text_byte <= CH_TILDE)
		                 || text_byte == CH_BANG);
		cls.sp_tab     = live && (text_byte == CH_SPACE || text_byte == CH_TAB);
		cls.nl         = live && text_byte == CH_NL;
		cls.slash      = live && text_byte == CH_SLASH;
		cls.star       = live && text_byte == CH_STAR;
		cls.pct        = live && text_byte == CH_PCT;
		cls.plus_minus = live && (text_byte == CH_PLUS || text_byte == CH_MINUS);
		cls.eq         = live && text_byte == CH_EQ;
		cls.dot        = live && text_byte == CH_DOT;
		cls.zero       = live && text_byte == CH_ZERO;
		cls.squote     = live && text_byte == CH_SQUOTE;
		cls.dquote     = live && text_byte == CH_DQUOTE;
		cls.bslash     = live && text_byte == CH_BSLASH;
		cls.hash       = live && text_byte == CH_HASH;
		cls.exp_e      = live && (text_byte == CH_LO_E || text_byte == CH_UP_E);
	end

endmodule

// ===== src/stc_lexer.sv =====
module stc_lexer #(
	parameter int LENGTH_BITS = stc_pkg::LENGTH_BITS_DEF,
	parameter int LINE_BITS   = stc_pkg::LINE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   end_of_text,
	input  stc_pkg::char_class_t   cls,
	output logic                   res_valid,
	output stc_pkg::kind_t         res_kind,
	output logic                   res_run,
	output logic [LENGTH_BITS-1:0] res_len,
	output logic [LINE_BITS-1:0]   res_line
);
	import stc_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

	lex_state_t             state_q, state_d, nx, start;
	logic                   esc_q, esc_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_inc, str_len;
	logic [LINE_BITS-1:0]   line_q, line_d, line_inc;
	logic                   run_q, run_d;
	logic [LENGTH_BITS-1:0] run_len_q, run_len_d, run_base;
	logic                   fin;
	kind_t                  fin_kind;
	logic                   active, blk_ws;

	assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_ONE;
	assign run_base = run_q ? run_len_q : '0;
	assign active   = state_q != ST_IDLE;
	assign blk_ws   = cls.blk || cls.sp_tab || cls.nl;

	// A string reports its length without the two quotes.
	assign str_len = (len_q == LEN_MAX) ? len_q :
	                 (len_q >= LEN_TWO) ? len_q - LEN_TWO : '0;

	// State that a byte opens between tokens.
	always_comb begin
		start = ST_IDLE;
		if (cls.slash) start = ST_O3;
		else if (cls.star) start = ST_O2;
		else if (cls.pct) start = ST_O1;
		else if (cls.plus_minus) start = ST_O0;
		else if (cls.eq) start = ST_O6;
		else if (cls.dot) start = ST_E1;
		else if (cls.zero) start = ST_I0;
		else if (cls.dig) start = ST_I1;
		else if (cls.alpha) start = ST_V0;
		else if (cls.squote) start = ST_E5;
		else if (cls.dquote) start = ST_E4;
		else if (cls.hash) start = ST_C0;
	end

	// One transition of the automaton; fin marks the byte that ends a token.
	always_comb begin
		nx       = ST_IDLE;
		fin      = 1'b0;
		fin_kind = K_OP;
		unique case (state_q) inside
			ST_O0: begin
				if (cls.zero) nx = ST_I0;
				else if (cls.dig) nx = ST_I1;
				else if (cls.dot) nx = ST_E1;
				else if (cls.eq) nx = ST_O6;
				else begin fin = 1'b1; fin_kind = K_OP; end
			end
			ST_O1, ST_O4, ST_O5: begin
				if (cls.eq) nx = ST_O6;
				else begin fin = 1'b1; fin_kind = K_OP; end
			end
			ST_O2: begin
				if (cls.eq) nx = ST_O6;
				else if (cls.star) nx = ST_O4;
				else begin fin = 1'b1; fin_kind = K_OP; end
			end
			ST_O3: begin
				if (cls.eq) nx = ST_O6;
				else if (cls.slash) nx = ST_O5;
				else begin fin = 1'b1; fin_kind = K_OP; end
			end
			ST_O6: begin
				fin = 1'b1; fin_kind = K_OP;
			end
			ST_I0: begin
				if (cls.dig) nx = ST_E0;
				else if (cls.dot) nx = ST_F0;
				else begin fin = 1'b1; fin_kind = K_INT; end
			end
			ST_I1: begin
				if (cls.dig) nx = ST_I1;
				else if (cls.dot) nx = ST_F0;
				else begin fin = 1'b1; fin_kind = K_INT; end
			end
			ST_F0, ST_F1: begin
				if (cls.exp_e) nx = ST_E2;
				else if (cls.dig) nx = ST_F1;
				else begin fin = 1'b1; fin_kind = K_FLT; end
			end
			ST_F2: begin
				if (cls.dig) nx = ST_F2;
				else begin fin = 1'b1; fin_kind = K_FLT; end
			end
			ST_V0: begin
				if (cls.alpha || cls.dig) nx = ST_V0;
				else begin fin = 1'b1; fin_kind = K_ID; end
			end
			ST_S0, ST_S1: begin
				fin = 1'b1; fin_kind = K_STR;
			end
			ST_S2: begin
				if (cls.dquote) nx = ST_E7;
				else begin fin = 1'b1; fin_kind = K_STR; end
			end
			ST_C0: begin
				if (cls.prnt) nx = ST_C0;
				else begin fin = 1'b1; fin_kind = K_COM; end
			end
			ST_C1: begin
				if (cls.blk) nx = ST_E7;
				else if (cls.dquote) nx = ST_C1;
				else begin fin = 1'b1; fin_kind = K_COM; end
			end
			ST_E0: begin
				if (cls.dig) nx = ST_E0;
				else if (cls.dot) nx = ST_F0;
				else begin fin = 1'b1; fin_kind = K_BADNUM; end
			end
			ST_E1: begin
				if (cls.dig) nx = ST_F1;
				else begin fin = 1'b1; fin_kind = K_BADNUM; end
			end
			ST_E2: begin
				if (cls.dig) nx = ST_F2;
				else if (cls.plus_minus) nx = ST_E3;
				else begin fin = 1'b1; fin_kind = K_BADNUM; end
			end
			ST_E3: begin
				if (cls.dig) nx = ST_F2;
				else begin fin = 1'b1; fin_kind = K_BADNUM; end
			end
			ST_E4, ST_E6: begin
				if (cls.prnt && !cls.dquote) nx = ST_E6;
				else if (cls.dquote) begin
					if (esc_q) nx = ST_E6;
					else if (state_q == ST_E4) nx = ST_S2;
					else nx = ST_S1;
				end else begin fin = 1'b1; fin_kind = K_BAD; end
			end
			ST_E5: begin
				if (cls.prnt && !cls.squote) nx = ST_E5;
				else if (cls.squote) nx = esc_q ? ST_E5 : ST_S0;
				else begin fin = 1'b1; fin_kind = K_BAD; end
			end
			ST_E7, ST_E8, ST_E9: begin
				if (blk_ws) nx = ST_E7;
				else if (cls.dquote) begin
					if (state_q == ST_E7) nx = ST_E8;
					else if (state_q == ST_E8) nx = ST_E9;
					else nx = ST_C1;
				end else begin fin = 1'b1; fin_kind = K_BAD; end
			end
			default: begin
				nx  = ST_IDLE;
				fin = 1'b0;
			end
		endcase
	end

	// Update of the whole lexer state for one item, and its result.
	always_comb begin
		state_d   = state_q;
		esc_d     = esc_q;
		len_d     = len_q;
		line_d    = line_q;
		run_d     = run_q;
		run_len_d = run_len_q;
		res_valid = 1'b0;
		res_kind  = fin_kind;
		res_run   = 1'b0;
		res_len   = (fin_kind == K_STR) ? str_len : len_q;
		res_line  = line_q;
		if (active && !fin) begin
			if (state_q == ST_E4 || state_q == ST_E5 || state_q == ST_E6) begin
				esc_d = cls.bslash;
			end
			if ((state_q == ST_E7 || state_q == ST_E8 || state_q == ST_E9) && cls.nl) begin
				line_d = line_inc;
			end
			state_d = nx;
			len_d   = len_inc;
		end else begin
			res_valid = active;
			state_d   = ST_IDLE;
			if (end_of_text) begin
				if (run_q && !active) begin
					res_valid = 1'b1;
					res_kind  = K_BAD;
					res_run   = 1'b1;
					res_len   = run_len_q;
				end
				esc_d     = 1'b0;
				len_d     = '0;
				line_d    = LINE_ONE;
				run_d     = 1'b0;
				run_len_d = '0;
			end else if (cls.sp_tab || cls.nl || start != ST_IDLE) begin
				if (run_q && !active) begin
					res_valid = 1'b1;
					res_kind  = K_BAD;
					res_run   = 1'b1;
					res_len   = run_len_q;
				end
				run_d     = 1'b0;
				run_len_d = '0;
				if (cls.nl) begin
					line_d = line_inc;
				end else if (!cls.sp_tab) begin
					state_d = start;
					esc_d   = 1'b0;
					len_d   = LEN_ONE;
				end
			end else begin
				run_d     = 1'b1;
				run_len_d = (run_base == LEN_MAX) ? run_base : run_base + LEN_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			esc_q     <= 1'b0;
			len_q     <= '0;
			line_q    <= LINE_ONE;
			run_q     <= 1'b0;
			run_len_q <= '0;
		end else if (step) begin
			state_q   <= state_d;
			esc_q     <= esc_d;
			len_q     <= len_d;
			line_q    <= line_d;
			run_q     <= run_d;
			run_len_q <= run_len_d;
		end
	end

	// An unknown run only grows between tokens.
	a_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> state_q == ST_IDLE)
		else $error("unknown run active while a token is open");

	// The end marker leaves the lexer as after reset.
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_text |=> state_q == ST_IDLE && line_q == LINE_ONE && !run_q)
		else $error("end marker did not reset the lexer");

	// The line count saturates and never wraps to zero.
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count wrapped");

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stc_pkg::*;

	// Widths of the result fields follow the block's default parameters.
	localparam int LEN_W  = LENGTH_BITS_DEF;
	localparam int LINE_W = LINE_BITS_DEF;
	localparam logic [LEN_W-1:0]  LEN_TOP  = '1;
	localparam logic [LINE_W-1:0] LINE_TOP = '1;

	// A character as seen by the lexer: one byte, or NO_CHAR for the end marker.
	// The ninth bit keeps NO_CHAR outside every range test below.
	typedef logic [8:0] lex_char_t;
	localparam lex_char_t NO_CHAR = 9'h100;

	// Nothing may stand still for longer than this while the run is alive.
	localparam int WATCHDOG_LIMIT = 5000;
	// The long receiver hold-off starts once this many results have been seen.
	localparam int HOLD_AFTER     = 25;
	localparam int HOLD_CYCLES    = 300;

	typedef struct {
		logic [7:0] b;
		logic       eot;
	} byte_item_t;

	typedef struct {
		kind_t             kind;
		logic              run;
		logic [LEN_W-1:0]  len;
		logic [LINE_W-1:0] line;
	} token_rec_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [7:0]          text_byte    = 8'h00;
	logic                end_of_text  = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	kind_t               token_kind;
	logic                unknown_run;
	logic [LEN_W-1:0]    token_length;
	logic [LINE_W-1:0]   line_number;

	source_text_token_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.unknown_run  (unknown_run),
		.token_length (token_length),
		.line_number  (line_number)
	);

	// Bytes waiting to be offered, and tokens predicted but not yet seen.
	byte_item_t pending_bytes[$];
	token_rec_t expected_tokens[$];

	// Our own copy of the lexer's state.
	lex_state_t        lex_st;
	logic              esc_armed;
	logic [LEN_W-1:0]  tok_len_q;
	logic [LINE_W-1:0] cur_line;
	logic              junk_on;
	logic [LEN_W-1:0]  junk_len;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int stall_left    = 0;
	bit held_once     = 1'b0;
	int quiet_cycles  = 0;

	string op_spellings [0:10] = '{"+", "-", "*", "/", "%", "=", "**", "//", "+=", "-=", "//="};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Character classes. All of them are false for the end marker and for
	// bytes at 0x80 and above, which is exactly how the lexer treats them.
	// ------------------------------------------------------------------
	function automatic logic digit_ch(lex_char_t c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic letter_ch(lex_char_t c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_UNDER;
	endfunction

	function automatic logic printable_ch(lex_char_t c);
		return c >= CH_SPACE && c <= CH_TILDE;
	endfunction

	// Bytes that keep a triple-quoted block going: everything printable but the
	// double quote, plus newline and tab.
	function automatic logic block_ch(lex_char_t c);
		return (c >= CH_HASH && c <= CH_TILDE) || c == CH_SPACE || c == CH_BANG ||
			c == CH_NL || c == CH_TAB;
	endfunction

	function automatic logic space_ch(lex_char_t c);
		return c == CH_SPACE || c == CH_NL || c == CH_TAB;
	endfunction

	// The state a byte opens when it arrives between tokens; idle means it
	// opens nothing and so belongs to an unknown run (whitespace aside).
	function automatic lex_state_t opener_of(lex_char_t c);
		if (c == CH_SLASH) return ST_O3;
		if (c == CH_STAR) return ST_O2;
		if (c == CH_PCT) return ST_O1;
		if (c == CH_PLUS || c == CH_MINUS) return ST_O0;
		if (c == CH_EQ) return ST_O6;
		if (c == CH_DOT) return ST_E1;
		if (c == CH_ZERO) return ST_I0;
		if (digit_ch(c)) return ST_I1;
		if (letter_ch(c)) return ST_V0;
		if (c == CH_SQUOTE) return ST_E5;
		if (c == CH_DQUOTE) return ST_E4;
		if (c == CH_HASH) return ST_C0;
		return ST_IDLE;
	endfunction

	// One step of the automaton inside a token. When the byte cannot extend
	// the token, fin is raised and kind says what the finished token was.
	function automatic lex_state_t lex_next(input lex_state_t st, input lex_char_t c,
			input logic esc, output logic fin, output kind_t kind);
		logic dg;
		lex_state_t nx;
		dg = digit_ch(c);
		fin = 1'b0;
		kind = K_OP;
		nx = ST_IDLE;
		case (st)
			ST_O0: begin
				if (c == CH_ZERO) nx = ST_I0;
				else if (dg) nx = ST_I1;
				else if (c == CH_DOT) nx = ST_E1;
				else if (c == CH_EQ) nx = ST_O6;
				else fin = 1'b1;
			end
			ST_O1, ST_O4, ST_O5: begin
				if (c == CH_EQ) nx = ST_O6;
				else fin = 1'b1;
			end
			ST_O2: begin
				if (c == CH_EQ) nx = ST_O6;
				else if (c == CH_STAR) nx = ST_O4;
				else fin = 1'b1;
			end
			ST_O3: begin
				if (c == CH_EQ) nx = ST_O6;
				else if (c == CH_SLASH) nx = ST_O5;
				else fin = 1'b1;
			end
			ST_O6: fin = 1'b1;
			ST_I0: begin
				kind = K_INT;
				if (dg) nx = ST_E0;
				else if (c == CH_DOT) nx = ST_F0;
				else fin = 1'b1;
			end
			ST_I1: begin
				kind = K_INT;
				if (dg) nx = ST_I1;
				else if (c == CH_DOT) nx = ST_F0;
				else fin = 1'b1;
			end
			ST_F0, ST_F1: begin
				kind = K_FLT;
				if (c == CH_LO_E || c == CH_UP_E) nx = ST_E2;
				else if (dg) nx = ST_F1;
				else fin = 1'b1;
			end
			ST_F2: begin
				kind = K_FLT;
				if (dg) nx = ST_F2;
				else fin = 1'b1;
			end
			ST_V0: begin
				kind = K_ID;
				if (letter_ch(c) || dg) nx = ST_V0;
				else fin = 1'b1;
			end
			ST_S0, ST_S1: begin
				kind = K_STR;
				fin = 1'b1;
			end
			ST_S2: begin
				// An empty double-quoted string followed by a third quote
				// opens a triple-quoted block instead.
				kind = K_STR;
				if (c == CH_DQUOTE) nx = ST_E7;
				else fin = 1'b1;
			end
			ST_C0: begin
				kind = K_COM;
				if (printable_ch(c)) nx = ST_C0;
				else fin = 1'b1;
			end
			ST_C1: begin
				// Just after a closing triple quote: a visible byte resumes the
				// block, another quote waits, anything else closes it.
				kind = K_COM;
				if ((c >= CH_HASH && c <= CH_TILDE) || c == CH_BANG) nx = ST_E7;
				else if (c == CH_DQUOTE) nx = ST_C1;
				else fin = 1'b1;
			end
			ST_E0: begin
				kind = K_BADNUM;
				if (dg) nx = ST_E0;
				else if (c == CH_DOT) nx = ST_F0;
				else fin = 1'b1;
			end
			ST_E1, ST_E3: begin
				kind = K_BADNUM;
				if (dg) nx = (st == ST_E1) ? ST_F1 : ST_F2;
				else fin = 1'b1;
			end
			ST_E2: begin
				kind = K_BADNUM;
				if (dg) nx = ST_F2;
				else if (c == CH_PLUS || c == CH_MINUS) nx = ST_E3;
				else fin = 1'b1;
			end
			ST_E4, ST_E6: begin
				kind = K_BAD;
				if (printable_ch(c) && c != CH_DQUOTE) nx = ST_E6;
				else if (c == CH_DQUOTE) nx = esc ? ST_E6 : (st == ST_E4 ? ST_S2 : ST_S1);
				else fin = 1'b1;
			end
			ST_E5: begin
				kind = K_BAD;
				if (printable_ch(c) && c != CH_SQUOTE) nx = ST_E5;
				else if (c == CH_SQUOTE) nx = esc ? ST_E5 : ST_S0;
				else fin = 1'b1;
			end
			ST_E7, ST_E8, ST_E9: begin
				kind = K_BAD;
				if (block_ch(c)) nx = ST_E7;
				else if (c == CH_DQUOTE) nx = (st == ST_E7) ? ST_E8 : ((st == ST_E8) ? ST_E9 : ST_C1);
				else fin = 1'b1;
			end
			default: nx = ST_IDLE;
		endcase
		return nx;
	endfunction

	task automatic clear_lexer();
		lex_st    = ST_IDLE;
		esc_armed = 1'b0;
		tok_len_q = '0;
		cur_line  = LINE_W'(1);
		junk_on   = 1'b0;
		junk_len  = '0;
	endtask

	task automatic expect_token(kind_t kind, logic run, logic [LEN_W-1:0] len);
		token_rec_t t;
		t.kind = kind;
		t.run  = run;
		t.len  = len;
		t.line = cur_line;
		expected_tokens.push_back(t);
	endtask

	// Works out what one accepted byte (or end marker) does to the lexer and
	// queues the token it completes, if any.
	task automatic predict_token(input logic [7:0] b, input logic eot);
		lex_char_t c;
		lex_state_t nx;
		logic fin;
		logic emitted;
		logic absorbed;
		kind_t kind;
		logic [LEN_W-1:0] len;
		c = eot ? NO_CHAR : {1'b0, b};
		emitted = 1'b0;
		absorbed = 1'b0;
		if (lex_st != ST_IDLE) begin
			nx = lex_next(lex_st, c, esc_armed, fin, kind);
			if (!fin) begin
				absorbed = 1'b1;
				if (lex_st inside {ST_E4, ST_E5, ST_E6})
					esc_armed = (c == CH_BSLASH);
				if (lex_st inside {ST_E7, ST_E8, ST_E9} && c == CH_NL && cur_line != LINE_TOP)
					cur_line++;
				lex_st = nx;
				if (tok_len_q != LEN_TOP)
					tok_len_q++;
			end else begin
				// Strings are reported without their quotes, unless the
				// count has saturated.
				len = tok_len_q;
				if (kind == K_STR && len != LEN_TOP)
					len = (len >= LEN_W'(2)) ? len - LEN_W'(2) : '0;
				expect_token(kind, 1'b0, len);
				emitted = 1'b1;
			end
		end
		if (!absorbed) begin
			// The byte that ended a token starts the next item.
			lex_st = ST_IDLE;
			if (eot) begin
				if (junk_on && !emitted)
					expect_token(K_BAD, 1'b1, junk_len);
				clear_lexer();
			end else if (space_ch(c) || opener_of(c) != ST_IDLE) begin
				if (junk_on && !emitted)
					expect_token(K_BAD, 1'b1, junk_len);
				junk_on = 1'b0;
				junk_len = '0;
				if (c == CH_NL) begin
					if (cur_line != LINE_TOP)
						cur_line++;
				end else if (!space_ch(c)) begin
					lex_st = opener_of(c);
					esc_armed = 1'b0;
					tok_len_q = LEN_W'(1);
				end
			end else begin
				if (!junk_on) begin
					junk_on = 1'b1;
					junk_len = '0;
				end
				if (junk_len != LEN_TOP)
					junk_len++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus building blocks.
	// ------------------------------------------------------------------
	task automatic push_byte(logic [7:0] b);
		byte_item_t it;
		it.b = b;
		it.eot = 1'b0;
		pending_bytes.push_back(it);
	endtask

	task automatic push_end(logic [7:0] b);
		byte_item_t it;
		it.b = b;
		it.eot = 1'b1;
		pending_bytes.push_back(it);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] plain_char(logic [7:0] avoid);
		logic [7:0] b;
		do b = 8'($urandom_range(CH_TILDE, CH_SPACE)); while (b == avoid || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] letter_byte();
		int r;
		r = $urandom_range(52);
		if (r < 26) return 8'(CH_LO_A + r);
		if (r < 52) return 8'(CH_UP_A + r - 26);
		return CH_UNDER;
	endfunction

	// A byte that neither opens a token nor counts as whitespace.
	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (space_ch({1'b0, b}) || opener_of({1'b0, b}) != ST_IDLE);
		return b;
	endfunction

	task automatic push_digits(int n);
		repeat (n) push_byte(8'(CH_ZERO + $urandom_range(9)));
	endtask

	// Pushes one randomly chosen lexeme. Most are well formed with random
	// content; some are broken or plain noise.
	task automatic push_token();
		int pick;
		int sep;
		logic [7:0] q;
		logic [7:0] b;
		logic need_sep;
		pick = $urandom_range(99);
		need_sep = 1'b1;
		if (pick < 12) begin
			push_text(op_spellings[$urandom_range(10)]);
		end else if (pick < 24) begin
			if ($urandom_range(3) == 0) push_byte(CH_ZERO);
			else begin
				push_byte(8'(CH_ZERO + $urandom_range(9, 1)));
				push_digits($urandom_range(5));
			end
		end else if (pick < 34) begin
			if ($urandom_range(4) == 0) begin
				push_byte(CH_DOT);
				push_digits($urandom_range(3, 1));
			end else begin
				push_digits($urandom_range(3, 1));
				push_byte(CH_DOT);
				push_digits($urandom_range(3));
				if ($urandom_range(1)) begin
					push_byte($urandom_range(1) ? CH_LO_E : CH_UP_E);
					case ($urandom_range(2))
						0: push_byte(CH_PLUS);
						1: push_byte(CH_MINUS);
						default: ;
					endcase
					push_digits($urandom_range(2, 1));
				end
			end
		end else if (pick < 48) begin
			push_byte(letter_byte());
			repeat ($urandom_range(7))
				push_byte($urandom_range(2) ? letter_byte() : 8'(CH_ZERO + $urandom_range(9)));
		end else if (pick < 62) begin
			// Quoted string, now and then with escapes or left open.
			q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
			push_byte(q);
			repeat ($urandom_range(8)) begin
				if ($urandom_range(7) == 0) begin
					push_byte(CH_BSLASH);
					push_byte(8'($urandom_range(CH_TILDE, CH_SPACE)));
				end else push_byte(plain_char(q));
			end
			if ($urandom_range(7) != 0) push_byte(q);
			else begin
				push_byte($urandom_range(1) ? CH_NL : 8'(8'h80 + $urandom_range(127)));
				need_sep = 1'b0;
			end
		end else if (pick < 70) begin
			// Hash comment, closed by a newline or a tab.
			push_byte(CH_HASH);
			repeat ($urandom_range(10)) push_byte(8'($urandom_range(CH_TILDE, CH_SPACE)));
			push_byte($urandom_range(3) ? CH_NL : CH_TAB);
			need_sep = 1'b0;
		end else if (pick < 78) begin
			// Triple-quoted block over several lines, sometimes resumed after
			// its closing quotes.
			push_text("\"\"\"");
			repeat ($urandom_range(12)) begin
				case ($urandom_range(9))
					0: push_byte(CH_NL);
					1: push_byte(CH_TAB);
					2: begin
						push_byte(CH_DQUOTE);
						push_byte(plain_char(CH_DQUOTE));
					end
					default: push_byte(plain_char(CH_DQUOTE));
				endcase
			end
			push_text("\"\"\"");
			if ($urandom_range(2) == 0) begin
				b = plain_char(CH_DQUOTE);
				push_byte(b == CH_SPACE ? CH_BANG : b);
				repeat ($urandom_range(3)) push_byte(plain_char(CH_DQUOTE));
				push_text("\"\"\"");
			end
			push_byte($urandom_range(1) ? CH_SPACE : CH_NL);
			need_sep = 1'b0;
		end else if (pick < 84) begin
			case ($urandom_range(3))
				0: begin
					push_byte(CH_ZERO);
					push_digits($urandom_range(3, 1));
				end
				1: push_byte(CH_DOT);
				2: begin
					push_digits($urandom_range(2, 1));
					push_text(".e");
				end
				default: begin
					push_digits($urandom_range(2, 1));
					push_text(".5E-");
				end
			endcase
		end else if (pick < 96) begin
			repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
			need_sep = 1'b0;
		end else begin
			push_end(8'($urandom_range(255)));
			need_sep = 1'b0;
		end
		if (need_sep) begin
			sep = $urandom_range(9);
			if (sep < 4) push_byte(CH_SPACE);
			else if (sep < 6) push_byte(CH_NL);
			else if (sep == 6) push_byte(CH_TAB);
		end
	endtask

	task automatic push_random(int count);
		int stop_at;
		stop_at = pending_bytes.size() + count;
		while (pending_bytes.size() < stop_at)
			push_token();
	endtask

	// Holds the sender back until everything queued has gone in and every
	// result it caused has come out.
	task automatic wait_drain();
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_token();
		token_rec_t want;
		results_seen++;
		if (expected_tokens.size() == 0) begin
			report_mismatch($sformatf("result %0d (kind %0d, length %0d) with none expected",
				results_seen, token_kind, token_length));
		end else begin
			want = expected_tokens.pop_front();
			if (token_kind !== want.kind)
				report_mismatch($sformatf("result %0d kind %0d, expected %0d",
					results_seen, token_kind, want.kind));
			if (unknown_run !== want.run)
				report_mismatch($sformatf("result %0d unknown_run %0b, expected %0b",
					results_seen, unknown_run, want.run));
			if (token_length !== want.len)
				report_mismatch($sformatf("result %0d length %0d, expected %0d",
					results_seen, token_length, want.len));
			if (line_number !== want.line)
				report_mismatch($sformatf("result %0d line %0d, expected %0d",
					results_seen, line_number, want.line));
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the next pending item whenever the channel is free,
	// leaving gaps at the current idle rate. An offered item stays put
	// until the block takes it, and each accepted item is fed to the
	// predictor at the edge where it was taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : byte_driver
		byte_item_t nxt;
		if (!arst_n) begin
			clear_lexer();
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_token(text_byte, end_of_text);
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_bytes.pop_front();
					in_valid    <= 1'b1;
					text_byte   <= nxt.b;
					end_of_text <= nxt.eot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks every result taken and decides the ready level for
	// the next cycle. Once, early on, it refuses results for a long stretch
	// so that the block fills up and has to push back on its input.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_token();
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!held_once && results_seen >= HOLD_AFTER) begin
				held_once = 1'b1;
				stall_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: a run in which no item moves on either side for too long has
	// hung, or the block has lost a result we are still waiting for.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, expected_tokens.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run: directed bytes, then three random phases with
	// different idle patterns.
	// ------------------------------------------------------------------
	initial begin
		// An unknown run that includes a byte above 0x7F, closed by an operator.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("+=");
		// Float with an exponent straight after the point.
		push_text("0.e5");
		push_byte(CH_SPACE);
		// A string holding an escaped quote.
		push_text("\"\\\"\"");
		// A triple-quoted block that carries on after its first closing quotes.
		push_text("\"\"\"x\"\"\"y\"\"\"");
		push_byte(CH_NL);
		push_end(8'hFF);

		// Phase one: the sender idles now and then, the receiver mostly.
		send_idle_pct = 19;
		recv_idle_pct = 74;
		push_random(230);
		push_end(8'h00);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait_drain();

		// Phase two: the other way round.
		send_idle_pct = 74;
		recv_idle_pct = 19;
		push_random(240);
		push_end(8'h00);
		wait_drain();

		// Phase three: both sides at full rate.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random(240);
		push_end(8'($urandom_range(255)));
		wait_drain();

		// Wait on after draining so that any stray result still shows up.
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/stc_pkg.sv
src/stc_classify.sv
src/stc_lexer.sv
src/source_text_token_classifier.sv
sim/testbench.sv
